@@ rtl/utfesc_pkg.sv @@
// Shared types and constants for the UTF-8 string escaper.
package utfesc_pkg;

	// Kind of output token; each token expands to a fixed number of output bytes
	typedef enum logic [1:0] {
		TK_LIT,   // one byte copied as it is
		TK_ESC,   // backslash plus letter
		TK_REPL,  // U+FFFD, three bytes
		TK_HEX    // backslash, x, two uppercase hex digits
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [7:0]  data;      // literal byte, escape letter or byte to print in hex
		logic        run_last;  // last token caused by its input byte
		logic        str_end;   // last token of the whole string
	} tok_t;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] REPL_B0   = 8'hEF;
	localparam logic [7:0] REPL_B1   = 8'hBF;
	localparam logic [7:0] REPL_B2   = 8'hBD;

endpackage

@@ rtl/utfesc_front.sv @@
// Front end: accepts input bytes, tracks held UTF-8 bytes and issues output tokens.
module utfesc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] in_byte
	input  logic               s_tlast,   // last_in
	output logic               tok_valid,
	input  logic               tok_ready,
	output utfesc_pkg::tok_t   tok
);
	import utfesc_pkg::*;

	typedef enum logic {F_IDLE, F_EMIT} fstate_t;

	fstate_t     state_q;
	logic [1:0]  pcnt_q;
	logic [1:0]  idx_q;
	logic [7:0]  pend_q [3];
	logic [7:0]  wk_q [4];
	logic [7:0]  b_q;
	logic        last_q;
	logic        copy_q;
	logic [2:0]  nf_q;
	logic [2:0]  ntok_q;

	logic        acc;
	logic        cont;
	logic        lead;
	logic [2:0]  need;
	logic        hold_en;
	logic [1:0]  hold_idx;
	logic [1:0]  nx_pcnt;
	logic        nx_copy;
	logic [2:0]  nx_nf;
	logic [2:0]  nx_ntok;
	logic        last_tok;
	tok_t        t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd4;
		if ((b & 8'hE0) == 8'hC0) n = 3'd2;
		else if ((b & 8'hF0) == 8'hE0) n = 3'd3;
		return n;
	endfunction

	// Token for a byte that starts a new character (a held lead never gets here)
	function automatic tok_t fresh_tok(input logic [7:0] b);
		tok_t r;
		r.kind     = TK_LIT;
		r.data     = b;
		r.run_last = 1'b0;
		r.str_end  = 1'b0;
		if (b < 8'h80) begin
			case (b)
				8'h0A: begin r.kind = TK_ESC; r.data = 8'h6E; end  // n
				8'h0D: begin r.kind = TK_ESC; r.data = 8'h72; end  // r
				8'h09: begin r.kind = TK_ESC; r.data = 8'h74; end  // t
				8'h08: begin r.kind = TK_ESC; r.data = 8'h62; end  // b
				8'h0C: begin r.kind = TK_ESC; r.data = 8'h66; end  // f
				8'h0B: begin r.kind = TK_ESC; r.data = 8'h76; end  // v
				default: begin
					if (b <= 8'h1F || b == 8'h7F) r.kind = TK_HEX;
				end
			endcase
		end else if (b <= 8'h9F) begin
			r.kind = TK_HEX;
		end else begin
			r.kind = TK_REPL;  // stray continuation, bad lead or truncated lead
		end
		return r;
	endfunction

	// Held continuation byte judged alone
	function automatic tok_t cont_tok(input logic [7:0] b);
		tok_t r;
		r.kind     = (b <= 8'h9F) ? TK_HEX : TK_REPL;
		r.data     = b;
		r.run_last = 1'b0;
		r.str_end  = 1'b0;
		return r;
	endfunction

	assign s_tready  = (state_q == F_IDLE);
	assign tok_valid = (state_q == F_EMIT);
	assign acc       = s_tvalid && s_tready;

	// Decide what the accepted byte does with the held bytes
	always_comb begin
		cont     = (s_tdata[7:6] == 2'b10);
		lead     = (s_tdata >= 8'hC0) && (s_tdata < 8'hF8);
		need     = lead_len(pend_q[0]);
		hold_en  = 1'b0;
		hold_idx = 2'd0;
		nx_pcnt  = 2'd0;
		nx_copy  = 1'b0;
		nx_nf    = 3'd0;
		nx_ntok  = 3'd0;
		if (pcnt_q == 2'd0) begin
			if (lead && !s_tlast) begin
				hold_en = 1'b1;
				nx_pcnt = 2'd1;
			end else begin
				nx_ntok = 3'd1;
			end
		end else if (cont) begin
			if (({1'b0, pcnt_q} + 3'd1) >= need) begin
				nx_copy = 1'b1;
				nx_ntok = {1'b0, pcnt_q} + 3'd1;
			end else if (s_tlast) begin
				nx_nf   = {1'b0, pcnt_q} + 3'd1;
				nx_ntok = {1'b0, pcnt_q} + 3'd1;
			end else begin
				hold_en  = 1'b1;
				hold_idx = pcnt_q;
				nx_pcnt  = pcnt_q + 2'd1;
			end
		end else begin
			nx_nf = {1'b0, pcnt_q};
			if (lead && !s_tlast) begin
				hold_en = 1'b1;
				nx_pcnt = 2'd1;
				nx_ntok = {1'b0, pcnt_q};
			end else begin
				nx_ntok = {1'b0, pcnt_q} + 3'd1;
			end
		end
	end

	// Token at the current step of the sequence
	always_comb begin
		if (copy_q) begin
			t.kind     = TK_LIT;
			t.data     = wk_q[idx_q];
			t.run_last = 1'b0;
			t.str_end  = 1'b0;
		end else if ({1'b0, idx_q} < nf_q) begin
			if (idx_q == 2'd0) begin
				t.kind     = TK_REPL;
				t.data     = 8'h00;
				t.run_last = 1'b0;
				t.str_end  = 1'b0;
			end else begin
				t = cont_tok(wk_q[idx_q]);
			end
		end else begin
			t = fresh_tok(b_q);
		end
		last_tok   = ({1'b0, idx_q} == (ntok_q - 3'd1));
		t.run_last = last_tok;
		t.str_end  = last_tok && last_q;
	end

	assign tok = t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pcnt_q  <= 2'd0;
			idx_q   <= 2'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (acc) begin
						pcnt_q <= nx_pcnt;
						idx_q  <= 2'd0;
						if (nx_ntok != 3'd0) state_q <= F_EMIT;
					end
				end
				F_EMIT: begin
					if (tok_ready) begin
						if (last_tok) state_q <= F_IDLE;
						else idx_q <= idx_q + 2'd1;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (hold_en) pend_q[hold_idx] <= s_tdata;
			for (int i = 0; i < 3; i++) begin
				wk_q[i] <= (pcnt_q == 2'(i)) ? s_tdata : pend_q[i];
			end
			wk_q[3] <= s_tdata;
			b_q     <= s_tdata;
			last_q  <= s_tlast;
			copy_q  <= nx_copy;
			nf_q    <= nx_nf;
			ntok_q  <= nx_ntok;
		end
	end

endmodule

@@ rtl/utfesc_fifo.sv @@
// Short token queue between the front and back ends.
module utfesc_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  utfesc_pkg::tok_t   in_tok,
	output logic               out_valid,
	input  logic               out_ready,
	output utfesc_pkg::tok_t   out_tok
);
	import utfesc_pkg::*;

	tok_t            mem_q [QDEPTH];
	logic [QAW-1:0]  wr_q;
	logic [QAW-1:0]  rd_q;
	logic [QCW-1:0]  cnt_q;
	logic            push;
	logic            pop;

	assign in_ready  = (cnt_q != QCW'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_tok   = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QAW'(1);
			if (pop)  rd_q <= rd_q + QAW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_tok;
	end

endmodule

@@ rtl/utfesc_back.sv @@
// Back end: expands tokens to output bytes, one per cycle when not stalled, via an output register.
module utfesc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	output logic               tok_ready,
	input  utfesc_pkg::tok_t   tok,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [7:0] out_byte
	output logic               m_tlast,   // run_last
	output logic               m_tuser    // string_end
);
	import utfesc_pkg::*;

	tok_t        cur_q;
	logic        cur_v_q;
	logic [1:0]  pos_q;
	logic        adv;
	logic        end_tok;
	logic [1:0]  len_m1;
	logic [7:0]  byte_nx;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h41 + {4'h0, v} - 8'd10);
	endfunction

	always_comb begin
		case (cur_q.kind)
			TK_LIT:  len_m1 = 2'd0;
			TK_ESC:  len_m1 = 2'd1;
			TK_REPL: len_m1 = 2'd2;
			TK_HEX:  len_m1 = 2'd3;
			default: len_m1 = 2'd0;
		endcase
		case (cur_q.kind)
			TK_LIT:  byte_nx = cur_q.data;
			TK_ESC:  byte_nx = (pos_q == 2'd0) ? CH_BSLASH : cur_q.data;
			TK_REPL: byte_nx = (pos_q == 2'd0) ? REPL_B0 :
			                   (pos_q == 2'd1) ? REPL_B1 : REPL_B2;
			TK_HEX: begin
				case (pos_q)
					2'd0:    byte_nx = CH_BSLASH;
					2'd1:    byte_nx = CH_X;
					2'd2:    byte_nx = hex_digit(cur_q.data[7:4]);
					default: byte_nx = hex_digit(cur_q.data[3:0]);
				endcase
			end
			default: byte_nx = cur_q.data;
		endcase
	end

	assign end_tok   = (pos_q == len_m1);
	assign adv       = cur_v_q && (!m_tvalid || m_tready);
	assign tok_ready = !cur_v_q || (adv && end_tok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q  <= 1'b0;
			pos_q    <= 2'd0;
			m_tvalid <= 1'b0;
			m_tlast  <= 1'b0;
			m_tuser  <= 1'b0;
		end else begin
			if (adv) begin
				m_tvalid <= 1'b1;
				m_tlast  <= cur_q.run_last && end_tok;
				m_tuser  <= cur_q.str_end && end_tok;
				pos_q    <= end_tok ? 2'd0 : pos_q + 2'd1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (tok_ready) cur_v_q <= tok_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) m_tdata <= byte_nx;
		if (tok_ready && tok_valid) cur_q <= tok;
	end

endmodule

@@ rtl/utf8_string_escaper.sv @@
// Top level of the UTF-8 string escaper: front end, token queue and back end.
// Path: an input byte's tokens pass the front-end registers, the token queue and the back-end
// token register before the output register. Throughput: the front end takes no new input
// byte while it issues the 0 to 4 tokens of the last one; the back end sends one output
// byte per cycle while m_tready does not stall it, 0 to 15 per input byte.
// Reset: arst_n clears held-byte count, queue and output register; held bytes are not cleared.
module utf8_string_escaper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // last_in: final byte of the string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // run_last: last output byte caused by one input byte
	output logic        m_tuser    // string_end: final output byte of the string
);
	import utfesc_pkg::*;

	// Front to queue
	logic  fq_valid;
	logic  fq_ready;
	tok_t  fq_tok;
	// Queue to back
	logic  qb_valid;
	logic  qb_ready;
	tok_t  qb_tok;

	// Front end: classifies each byte against the held UTF-8 bytes and issues one token
	// per cycle while the queue has room (literal, escape, replacement or hex escape).
	utfesc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.tok_valid (fq_valid),
		.tok_ready (fq_ready),
		.tok       (fq_tok)
	);

	// Token queue lets the front take new bytes while the back drains long escapes
	utfesc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_tok    (fq_tok),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_tok   (qb_tok)
	);

	// Back end: one output byte per transfer, output register decouples the master side
	utfesc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (qb_valid),
		.tok_ready (qb_ready),
		.tok       (qb_tok),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

@@ rtl/utfesc_checker.sv @@
// Port-level checker for the UTF-8 string escaper, bound to the top level.
module utfesc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	input  logic        m_tuser
);
	// Strings whose final byte went in but whose end has not come out
	logic [3:0] open_q;
	logic       in_end;
	logic       out_end;

	assign in_end  = s_tvalid && s_tready && s_tlast;
	assign out_end = m_tvalid && m_tready && m_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 4'd0;
		end else begin
			case ({in_end, out_end})
				2'b10:   open_q <= open_q + 4'd1;
				2'b01:   open_q <= open_q - 4'd1;
				default: open_q <= open_q;
			endcase
		end
	end

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("string end without run end");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled output transfer changed");

	a_end_has_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_end |-> open_q != 4'd0)
		else $error("string end with no final input byte taken");

endmodule

bind utf8_string_escaper utfesc_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
